// ===== hdl/swaf_pkg.sv =====
// ----------------------------------------------------------------------------
// swaf_pkg
// Shared types and constants of the sliding-window anagram finder.
// ----------------------------------------------------------------------------
package swaf_pkg;

  localparam int OP_W              = 2;
  localparam int LETTER_W          = 5;
  localparam int POS_W             = 16;
  localparam int MAX_PATTERN_DEF   = 64;
  localparam int ALPHABET_SIZE_DEF = 26;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Update request for the two histograms.
  typedef struct packed {
    logic                clear;
    logic                pat_inc;
    logic                win_inc;
    logic                win_dec;
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] old_letter;
  } hist_cmd_t;

  // One result word.
  typedef struct packed {
    logic             matched;
    logic             done_res;
    logic [POS_W-1:0] start_index;
    logic [POS_W-1:0] end_index;
  } res_t;

endpackage

// ===== hdl/sliding_window_anagram_finder.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder
// Finds the first window of a text letter stream that is an anagram of a
// loaded pattern, using letter histograms and a delay line of recent letters.
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   in       in_valid_i / in_stall_o   operation_i, letter_i
//   out      out_valid_o / out_stall_i matched_o, done_res_o, start_index_o,
//                                      end_index_o
//
// One word per cycle while in_stall_o is low: each word is applied to the histograms,
// counters and delay line in the cycle it is accepted; its result is registered
// in the output buffer. The delay line is read ahead, at the slot the next letter retires.
// Only text letters produce a result. in_stall_o rises only when both the
// output register and the skid register hold results.
// Reset clears all control state and both histograms; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_anagram_finder
  import swaf_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [LETTER_W-1:0] letter_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                matched_o,
  output logic                done_res_o,
  output logic [POS_W-1:0]    start_index_o,
  output logic [POS_W-1:0]    end_index_o
);

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int SLOT_W = $clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2);

  logic [CNT_W-1:0]  plen_q, plen_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  fstart_q, fstart_d;
  logic [POS_W-1:0]  fend_q, fend_d;
  logic              found_q, found_d;
  logic              started_q, started_d;

  logic                accept;
  logic                letter_ok;
  logic                full;
  logic                equal;
  logic                push;
  res_t                res;
  res_t                out_data;
  hist_cmd_t           cmd;
  logic                wr_en;
  logic [LETTER_W-1:0] old_letter;
  logic [CNT_W:0]      rd_sum;
  logic [SLOT_W-1:0]   rd_slot;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;
  assign letter_ok  = 32'(letter_i) < ALPHABET_SIZE;

  always_comb begin
    plen_d     = plen_q;
    fill_d     = fill_q;
    slot_d     = slot_q;
    pos_d      = pos_q;
    fstart_d   = fstart_q;
    fend_d     = fend_q;
    found_d    = found_q;
    started_d  = started_q;
    cmd        = '0;
    cmd.letter = letter_i;
    cmd.old_letter = old_letter;
    wr_en      = 1'b0;
    push       = 1'b0;
    res        = '0;
    if (accept) begin
      case (operation_i)
        OP_CLEAR: begin
          plen_d    = '0;
          fill_d    = '0;
          slot_d    = '0;
          pos_d     = '0;
          fstart_d  = '0;
          fend_d    = '0;
          found_d   = 1'b0;
          started_d = 1'b0;
          cmd.clear = 1'b1;
        end
        OP_LOAD: begin
          if (letter_ok && !started_q && (plen_q < CNT_W'(MAX_PATTERN))) begin
            cmd.pat_inc = 1'b1;
            plen_d      = plen_q + CNT_W'(1);
          end
        end
        OP_TEXT: begin
          if (letter_ok) begin
            started_d = 1'b1;
            push      = 1'b1;
            if (pos_q != '1) begin
              pos_d = pos_q + POS_W'(1);
            end
            if (found_q) begin
              res.done_res    = 1'b1;
              res.start_index = fstart_q;
              res.end_index   = fend_q;
            end else begin
              if (plen_q != '0) begin
                // retire the oldest letter once the window is full
                if (fill_q >= plen_q) begin
                  cmd.win_dec = 1'b1;
                end else begin
                  fill_d = fill_q + CNT_W'(1);
                end
                cmd.win_inc = 1'b1;
                wr_en       = 1'b1;
                slot_d      = (slot_q == SLOT_W'(MAX_PATTERN - 1)) ? '0
                                                                   : slot_q + SLOT_W'(1);
              end
              if (equal) begin
                found_d         = 1'b1;
                // an empty pattern matches on this letter alone
                fstart_d        = (plen_q == '0) ? pos_q
                                                 : pos_q + POS_W'(1) - POS_W'(plen_q);
                fend_d          = pos_q;
                res.matched     = 1'b1;
                res.start_index = fstart_d;
                res.end_index   = pos_q;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch the slot the next text letter retires.
  always_comb begin
    rd_sum = (CNT_W+1)'(slot_d) + (CNT_W+1)'(MAX_PATTERN) - (CNT_W+1)'(plen_d);
    if (rd_sum >= (CNT_W+1)'(MAX_PATTERN)) begin
      rd_slot = SLOT_W'(rd_sum - (CNT_W+1)'(MAX_PATTERN));
    end else begin
      rd_slot = SLOT_W'(rd_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= '0;
      fill_q    <= '0;
      slot_q    <= '0;
      pos_q     <= '0;
      fstart_q  <= '0;
      fend_q    <= '0;
      found_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      plen_q    <= plen_d;
      fill_q    <= fill_d;
      slot_q    <= slot_d;
      pos_q     <= pos_d;
      fstart_q  <= fstart_d;
      fend_q    <= fend_d;
      found_q   <= found_d;
      started_q <= started_d;
    end
  end

  swaf_hist #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .equal_o (equal)
  );

  swaf_delay #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_delay (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_slot_i   (slot_q),
    .wr_letter_i (letter_i),
    .rd_slot_i   (rd_slot),
    .rd_letter_o (old_letter)
  );

  swaf_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign matched_o     = out_data.matched;
  assign done_res_o    = out_data.done_res;
  assign start_index_o = out_data.start_index;
  assign end_index_o   = out_data.end_index;

endmodule

// ===== hdl/swaf_hist.sv =====
// ----------------------------------------------------------------------------
// swaf_hist
// Pattern and window letter histograms, one counter cell per letter, and the
// equality check of the updated window against the pattern.
// ----------------------------------------------------------------------------
module swaf_hist
  import swaf_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hist_cmd_t cmd_i,
  output logic      equal_o
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [CNT_W-1:0] pat_q [ALPHABET_SIZE];
  logic [CNT_W-1:0] pat_d [ALPHABET_SIZE];
  logic [CNT_W-1:0] win_q [ALPHABET_SIZE];
  logic [CNT_W-1:0] win_d [ALPHABET_SIZE];

  always_comb begin
    equal_o = 1'b1;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pat_d[i] = pat_q[i];
      win_d[i] = win_q[i];
      if (cmd_i.pat_inc && (32'(cmd_i.letter) == i)) begin
        pat_d[i] = pat_q[i] + CNT_W'(1);
      end
      if (cmd_i.win_inc && (32'(cmd_i.letter) == i)) begin
        win_d[i] = win_d[i] + CNT_W'(1);
      end
      if (cmd_i.win_dec && (32'(cmd_i.old_letter) == i)) begin
        win_d[i] = win_d[i] - CNT_W'(1);
      end
      if (cmd_i.clear) begin
        pat_d[i] = '0;
        win_d[i] = '0;
      end
      // compare the window as it stands after this letter
      if (win_d[i] != pat_q[i]) begin
        equal_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        pat_q[i] <= '0;
        win_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        pat_q[i] <= pat_d[i];
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

// ===== hdl/swaf_delay.sv =====
// ----------------------------------------------------------------------------
// swaf_delay
// Delay line of recent text letters. One write and one registered read per
// cycle; a read of the slot written in the same cycle returns the new letter.
// ----------------------------------------------------------------------------
module swaf_delay
  import swaf_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [$clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2)-1:0] wr_slot_i,
  input  logic [LETTER_W-1:0] wr_letter_i,
  input  logic [$clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2)-1:0] rd_slot_i,
  output logic [LETTER_W-1:0] rd_letter_o
);

  logic [LETTER_W-1:0] mem [MAX_PATTERN];
  logic [LETTER_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i] <= wr_letter_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == rd_slot_i)) begin
      rd_q <= wr_letter_i;
    end else begin
      rd_q <= mem[rd_slot_i];
    end
  end

  assign rd_letter_o = rd_q;

endmodule

// ===== hdl/swaf_obuf.sv =====
// ----------------------------------------------------------------------------
// swaf_obuf
// Two-entry result buffer: output register plus skid register, so the input
// side keeps flowing while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module swaf_obuf
  import swaf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic head_valid_q, head_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t head_q, head_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = head_valid_q && !out_stall_i;

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!head_valid_d) begin
        head_d       = push_data_i;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

endmodule
